/* rtl/core/trrb_pkg.sv */
// Package for the two-reader byte ring buffer: sizes, position type,
// RAM request struct, command codes and pointer helper functions.
// No dependencies; used by trrb_ram and two_reader_ring_buffer_drop_slowest.
`default_nettype none

package trrb_pkg;

  // Ring size in bytes
  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Unread count spans 0..DEPTH
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DROP_W = 32;

  // Result tdata layout: read_data, avail_count, drop_count (low to high)
  localparam int unsigned OUT_DATA_LSB  = 0;
  localparam int unsigned OUT_AVAIL_LSB = OUT_DATA_LSB + BYTE_W;
  localparam int unsigned OUT_DROP_LSB  = OUT_AVAIL_LSB + CNT_W;
  localparam int unsigned OUT_BITS      = OUT_DROP_LSB + DROP_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Request tuser bits
  localparam int unsigned IN_CMD_BIT    = 0;
  localparam int unsigned IN_READER_BIT = 1;

  // Command and reader codes
  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_READ      = 1'b1;
  localparam logic READER_DEMOD  = 1'b0;
  localparam logic READER_SPEC   = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DROP_W-1:0] drop_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Position modulo 2*DEPTH: lap bit plus storage slot
  typedef struct packed {
    logic  wrap;
    slot_t slot;
  } pos_t;

  // One write port and one read port of the byte store
  typedef struct packed {
    logic  we;
    slot_t waddr;
    byte_t wdata;
    logic  re;
    slot_t raddr;
  } ram_req_t;

  // Advance a position by one, toggling the lap bit at the end of the ring
  function automatic pos_t pos_next(pos_t p);
    pos_t n;
    n = p;
    if (p.slot == slot_t'(DEPTH - 1)) begin
      n.slot = '0;
      n.wrap = ~p.wrap;
    end else begin
      n.slot = p.slot + slot_t'(1);
    end
    return n;
  endfunction

  // Unread bytes between a read position and the write position
  function automatic cnt_t unread_of(pos_t w, pos_t r);
    cnt_t diff;
    diff = cnt_t'(w.slot) - cnt_t'(r.slot);
    if (w.wrap != r.wrap) begin
      diff = diff + cnt_t'(DEPTH);
    end
    return diff;
  endfunction

  // Saturating increment of a drop counter
  function automatic drop_t sat_inc(drop_t v);
    drop_t n;
    n = (v == '1) ? v : v + drop_t'(1);
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/two_reader_ring_buffer_drop_slowest.sv */
// Top level of the two-reader byte ring buffer with drop-oldest on full.
// Depends on trrb_pkg and trrb_ram.
//
//  channel | dir | tdata                                   | tuser
//  s_axis  | in  | [7:0] data_in                           | [0] cmd, [1] reader
//  m_axis  | out | [7:0] read_data, [20:8] avail_count,    | read_ok
//          |     | [52:21] drop_count, [55:53] zero        |
//
// One request per cycle while the result side keeps up; its result appears in
// the cycle after acceptance, from the registered read of the byte store and
// the result register. A request is taken whenever the result register is
// empty or is being drained in the same cycle. Reset clears the positions
// and drop counters at once; the byte store needs no clearing pass.
`default_nettype none

module two_reader_ring_buffer_drop_slowest (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_in
  input  wire logic [1:0] s_axis_tuser,   // [0] cmd, [1] reader
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [trrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // read_data, avail_count, drop_count
  output logic      m_axis_tuser          // read_ok
);

  trrb_pkg::pos_t  wr_q, wr_d;
  trrb_pkg::pos_t  rd0_q, rd0_d;
  trrb_pkg::pos_t  rd1_q, rd1_d;
  trrb_pkg::drop_t drops0_q, drops0_d;
  trrb_pkg::drop_t drops1_q, drops1_d;

  logic            out_valid_q;
  logic            ok_q, ok_d;
  trrb_pkg::cnt_t  avail_q, avail_d;
  trrb_pkg::drop_t drop_q, drop_d;

  trrb_pkg::ram_req_t ram_req;
  trrb_pkg::byte_t    ram_rdata;

  logic            accept;
  logic            cmd;
  logic            sel;
  trrb_pkg::cnt_t  unread0;
  trrb_pkg::cnt_t  unread1;
  trrb_pkg::cnt_t  unread_sel;
  logic            full0;
  logic            full1;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = s_axis_tuser[trrb_pkg::IN_CMD_BIT];
  assign sel           = s_axis_tuser[trrb_pkg::IN_READER_BIT];

  assign unread0    = trrb_pkg::unread_of(wr_q, rd0_q);
  assign unread1    = trrb_pkg::unread_of(wr_q, rd1_q);
  assign full0      = (unread0 == trrb_pkg::cnt_t'(trrb_pkg::DEPTH));
  assign full1      = (unread1 == trrb_pkg::cnt_t'(trrb_pkg::DEPTH));
  assign unread_sel = (sel == trrb_pkg::READER_SPEC) ? unread1 : unread0;

  // Pointer update, store access and result fields for one request
  always_comb begin
    wr_d     = wr_q;
    rd0_d    = rd0_q;
    rd1_d    = rd1_q;
    drops0_d = drops0_q;
    drops1_d = drops1_q;
    ok_d     = 1'b0;
    avail_d  = avail_q;
    ram_req  = '0;

    if (accept) begin
      case (cmd)
        trrb_pkg::CMD_WRITE: begin
          // Full ring: readers sitting on the oldest byte skip it
          if (full0) begin
            rd0_d    = trrb_pkg::pos_next(rd0_q);
            drops0_d = trrb_pkg::sat_inc(drops0_q);
          end
          if (full1) begin
            rd1_d    = trrb_pkg::pos_next(rd1_q);
            drops1_d = trrb_pkg::sat_inc(drops1_q);
          end
          ram_req.we    = 1'b1;
          ram_req.waddr = wr_q.slot;
          ram_req.wdata = s_axis_tdata;
          wr_d          = trrb_pkg::pos_next(wr_q);
          if (sel == trrb_pkg::READER_SPEC) begin
            avail_d = full1 ? unread1 : unread1 + trrb_pkg::cnt_t'(1);
          end else begin
            avail_d = full0 ? unread0 : unread0 + trrb_pkg::cnt_t'(1);
          end
        end
        trrb_pkg::CMD_READ: begin
          avail_d = unread_sel;
          if (unread_sel != '0) begin
            ok_d       = 1'b1;
            ram_req.re = 1'b1;
            avail_d    = unread_sel - trrb_pkg::cnt_t'(1);
            if (sel == trrb_pkg::READER_SPEC) begin
              ram_req.raddr = rd1_q.slot;
              rd1_d         = trrb_pkg::pos_next(rd1_q);
            end else begin
              ram_req.raddr = rd0_q.slot;
              rd0_d         = trrb_pkg::pos_next(rd0_q);
            end
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    drop_d = (sel == trrb_pkg::READER_SPEC) ? drops1_d : drops0_d;
  end

  // Ring positions and drop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= '0;
      rd0_q    <= '0;
      rd1_q    <= '0;
      drops0_q <= '0;
      drops1_q <= '0;
    end else begin
      wr_q     <= wr_d;
      rd0_q    <= rd0_d;
      rd1_q    <= rd1_d;
      drops0_q <= drops0_d;
      drops1_q <= drops1_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (accept) begin
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      avail_q <= avail_d;
      drop_q  <= drop_d;
    end
  end

  trrb_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Pack the result; read data only when a byte was delivered
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[trrb_pkg::OUT_DATA_LSB +: trrb_pkg::BYTE_W] =
      ok_q ? ram_rdata : '0;
    m_axis_tdata[trrb_pkg::OUT_AVAIL_LSB +: trrb_pkg::CNT_W] = avail_q;
    m_axis_tdata[trrb_pkg::OUT_DROP_LSB +: trrb_pkg::DROP_W] = drop_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = ok_q;

endmodule

`default_nettype wire

/* rtl/core/trrb_ram.sv */
// Byte store of the ring buffer: one write port, one registered read port.
// Depends on trrb_pkg for its depth and request struct.
`default_nettype none

module trrb_ram (
  input  wire logic              clk_i,
  input  wire trrb_pkg::ram_req_t req_i,
  output logic [trrb_pkg::BYTE_W-1:0] rdata_o
);

  trrb_pkg::byte_t mem [trrb_pkg::DEPTH];
  trrb_pkg::byte_t rdata_q;

  // Write and registered read; contents are undefined until written
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* tb/sv/ring_status_checker.sv */
// Scoreboard for the two-reader byte ring buffer: watches both stream
// channels, predicts every result and compares it field by field.
// Depends on trrb_pkg for widths, codes and result field offsets.
module ring_status_checker
  import trrb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic                   s_ready_i,
  input  logic [7:0]             s_data_i,    // [7:0] data_in
  input  logic [1:0]             s_user_i,    // [0] cmd, [1] reader
  input  logic                   m_valid_i,
  input  logic                   m_ready_i,
  input  logic [OUT_TDATA_W-1:0] m_data_i,    // read_data, avail_count, drop_count
  input  logic                   m_user_i,    // read_ok
  output int                     err_count_o,
  output int                     pending_o,
  output int                     checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Positions run modulo 2*DEPTH, so the unread count is a plain difference
  localparam int unsigned POS_W      = $clog2(2 * DEPTH);
  localparam int          MAX_PRINTS = 40;

  typedef logic [POS_W-1:0] ring_pos_t;

  typedef struct packed {
    byte_t rdata;
    logic  ok;
    cnt_t  avail;
    drop_t drops;
  } status_t;

  // Shadow copy of the ring
  byte_t     ring_bytes [DEPTH];
  ring_pos_t wr_pos;
  ring_pos_t rd_pos [2];
  drop_t     drop_tally [2];

  status_t   status_q [$];
  int        fails   = 0;
  int        checked = 0;

  task automatic note_failure(string msg);
    if (fails < MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    fails++;
  endtask

  // Apply one request to the shadow ring and return the status it reports
  function automatic status_t step_ring(logic cmd, logic rdr, byte_t din);
    status_t   st;
    ring_pos_t unread;
    st = '0;
    if (cmd == CMD_WRITE) begin
      // a reader sitting on the oldest byte of a full ring loses it
      for (int i = 0; i < 2; i++) begin
        unread = wr_pos - rd_pos[i];
        if (unread >= DEPTH) begin
          rd_pos[i] = rd_pos[i] + 1'b1;
          if (drop_tally[i] != '1) begin
            drop_tally[i] = drop_tally[i] + 1'b1;
          end
        end
      end
      ring_bytes[wr_pos[SLOT_W-1:0]] = din;
      wr_pos = wr_pos + 1'b1;
    end else begin
      if (wr_pos != rd_pos[rdr]) begin
        st.rdata   = ring_bytes[rd_pos[rdr][SLOT_W-1:0]];
        st.ok      = 1'b1;
        rd_pos[rdr] = rd_pos[rdr] + 1'b1;
      end
    end
    unread   = wr_pos - rd_pos[rdr];
    st.avail = cnt_t'(unread);
    st.drops = drop_tally[rdr];
    return st;
  endfunction

  // Results are compared before the same edge's request is predicted:
  // a result never belongs to a request accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    status_t want;
    status_t got;
    if (!rst_ni) begin
      wr_pos        = '0;
      rd_pos[0]     = '0;
      rd_pos[1]     = '0;
      drop_tally[0] = '0;
      drop_tally[1] = '0;
      status_q.delete();
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (status_q.size() == 0) begin
          note_failure("result with no request outstanding");
        end else begin
          want      = status_q.pop_front();
          got.rdata = m_data_i[OUT_DATA_LSB +: BYTE_W];
          got.ok    = m_user_i;
          got.avail = m_data_i[OUT_AVAIL_LSB +: CNT_W];
          got.drops = m_data_i[OUT_DROP_LSB +: DROP_W];
          if (got.rdata !== want.rdata) begin
            note_failure($sformatf("result %0d read_data %h, expected %h",
                                   checked, got.rdata, want.rdata));
          end
          if (got.ok !== want.ok) begin
            note_failure($sformatf("result %0d read_ok %b, expected %b",
                                   checked, got.ok, want.ok));
          end
          if (got.avail !== want.avail) begin
            note_failure($sformatf("result %0d avail_count %0d, expected %0d",
                                   checked, got.avail, want.avail));
          end
          if (got.drops !== want.drops) begin
            note_failure($sformatf("result %0d drop_count %0d, expected %0d",
                                   checked, got.drops, want.drops));
          end
          checked++;
        end
      end
      if (s_valid_i && s_ready_i) begin
        status_q.push_back(step_ring(s_user_i[IN_CMD_BIT], s_user_i[IN_READER_BIT],
                                     s_data_i));
      end
    end
    err_count_o <= fails;
    pending_o   <= status_q.size();
    checked_o   <= checked;
  end

endmodule

/* tb/sv/two_reader_ring_buffer_drop_slowest_tb.sv */
// Testbench top for the two-reader byte ring buffer: clock, reset, request
// and result stream drivers, watchdog and verdict.
// Depends on trrb_pkg, the block under test and ring_status_checker.
module two_reader_ring_buffer_drop_slowest_tb;
  import trrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;   // cycles with no handshake at all
  localparam int LONG_HOLD  = 400;    // receiver back-pressure stretch
  localparam int TAIL       = 4;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;   // [7:0] data_in
  logic [1:0]             s_axis_tuser  = '0;   // [0] cmd, [1] reader
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // read_data, avail_count, drop_count
  logic                   m_axis_tuser;         // read_ok

  int   err_count;
  int   pending_cnt;
  int   checked_cnt;

  bit   gaps_on   = 1'b1;
  int   hold_asks = 0;
  int   n_sent    = 0;
  int   n_writes  = 0;
  int   idle_cycles = 0;

  two_reader_ring_buffer_drop_slowest uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ring_status_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .err_count_o (err_count),
    .pending_o   (pending_cnt),
    .checked_o   (checked_cnt)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: ends the run if the stream stops moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Sender idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Random field values at their widths
  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_req(logic cmd, logic rdr, byte_t din);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    s_axis_tuser  <= {rdr, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
    if (cmd == CMD_WRITE) begin
      n_writes++;
    end
  endtask

  // Stop offering until every outstanding result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // Result side: ready runs broken by stalls, plus long holds on request
  initial begin : result_sink
    int holds_served;
    int ready_len;
    int stall_len;
    int r;
    holds_served = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_asks != holds_served) begin
        holds_served = hold_asks;
        ready_len    = 0;
        stall_len    = LONG_HOLD;
      end else if (r < 10) begin
        ready_len = $urandom_range(100, 300);   // no stalls for a while
        stall_len = 0;
      end else begin
        ready_len = $urandom_range(1, 40);
        stall_len = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (ready_len > 0) begin
        m_axis_tready <= 1'b1;
        repeat (ready_len) @(posedge clk_i);
      end
      if (stall_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int wr_pct;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty reads, byte extremes, both readers, read past the end
    send_req(CMD_READ,  READER_DEMOD, 8'hFF);
    send_req(CMD_READ,  READER_SPEC,  8'h00);
    send_req(CMD_WRITE, READER_DEMOD, 8'h00);
    send_req(CMD_WRITE, READER_SPEC,  8'hFF);
    send_req(CMD_WRITE, READER_DEMOD, 8'hA5);
    send_req(CMD_WRITE, READER_SPEC,  8'h5A);
    send_req(CMD_WRITE, READER_DEMOD, 8'h01);
    send_req(CMD_WRITE, READER_SPEC,  8'h80);
    repeat (3) send_req(CMD_READ, READER_DEMOD, rand_byte());
    repeat (7) send_req(CMD_READ, READER_SPEC,  rand_byte());
    repeat (4) send_req(CMD_READ, READER_DEMOD, rand_byte());
    wait_drained();

    // Random mix in segments: write-heavy, balanced and read-heavy
    for (int seg = 0; seg < 12; seg++) begin
      case ($urandom_range(0, 2))
        0:       wr_pct = 80;
        1:       wr_pct = 50;
        default: wr_pct = 25;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 100; k++) begin
        send_req(($urandom_range(0, 99) < wr_pct) ? CMD_WRITE : CMD_READ,
                 rand_bit(), rand_byte());
      end
      if (seg % 6 == 5) begin
        wait_drained();
      end
    end
    wait_drained();

    // Write burst while the result side holds off long enough to stall
    // the input
    gaps_on = 1'b0;
    hold_asks++;
    for (int k = 0; k < 400; k++) begin
      send_req(CMD_WRITE, rand_bit(), rand_byte());
    end
    // The readers fall apart from each other
    gaps_on = 1'b1;
    repeat (15) send_req(CMD_READ,  READER_DEMOD, rand_byte());
    repeat (10) send_req(CMD_WRITE, rand_bit(), rand_byte());
    repeat (7)  send_req(CMD_READ,  READER_SPEC,  rand_byte());
    repeat (12) send_req(CMD_WRITE, rand_bit(), rand_byte());
    wait_drained();

    // Read-heavy tail with a trickle of writes
    for (int seg = 0; seg < 2; seg++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 100; k++) begin
        send_req(($urandom_range(0, 99) < 3) ? CMD_WRITE : CMD_READ,
                 rand_bit(), rand_byte());
      end
    end

    wait_drained();
    repeat (TAIL) @(posedge clk_i);

    $display("Run covered %0d requests (%0d writes, %0d reads), %0d results checked,",
             n_sent, n_writes, n_sent - n_writes, checked_cnt);
    $display("including empty reads, both readers and a long result-side stall.");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* two_reader_ring_buffer_drop_slowest.f */
rtl/core/trrb_pkg.sv
rtl/core/trrb_ram.sv
rtl/core/two_reader_ring_buffer_drop_slowest.sv
tb/sv/ring_status_checker.sv
tb/sv/two_reader_ring_buffer_drop_slowest_tb.sv
